// ===== hdl/ajb_pkg.sv =====
// ajb_pkg: shared types, codes and helpers of the audio jitter buffer
// used by ajb_ctrl, ajb_datapath and audio_jitter_buffer; no dependencies

package ajb_pkg;

	localparam logic [15:0] HALF_RANGE = 16'h8000;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_TOO_OLD   = 3'd2,
		ST_FULL      = 3'd3,
		ST_WAIT      = 3'd4,
		ST_FRAME     = 3'd5,
		ST_MISSING   = 3'd6,
		ST_CLEARED   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_EXEC = 3'b100
	} fsm_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic exec;
	} cmd_t;

	// a is before b in wrapping sequence order
	function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = b - a;
		return (d != 16'd0) && (d < HALF_RANGE);
	endfunction

endpackage

// ===== hdl/ajb_ctrl.sv =====
// ajb_ctrl: sequencing state machine of the audio jitter buffer
// drives ajb_datapath through ajb_pkg::cmd_t; uses ajb_pkg

module ajb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output ajb_pkg::cmd_t cmd
);

	ajb_pkg::fsm_t state_q, state_n;
	logic          out_valid_q;
	logic          exec_fire;

	assign s_tready  = (state_q == ajb_pkg::S_IDLE);
	assign exec_fire = (state_q == ajb_pkg::S_EXEC) && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;

	assign cmd.load = s_tvalid && s_tready;
	assign cmd.cmp  = (state_q == ajb_pkg::S_CMP);
	assign cmd.exec = exec_fire;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ajb_pkg::S_IDLE: begin
				if (s_tvalid) state_n = ajb_pkg::S_CMP;
			end
			ajb_pkg::S_CMP: begin
				state_n = ajb_pkg::S_EXEC;
			end
			ajb_pkg::S_EXEC: begin
				if (exec_fire) state_n = ajb_pkg::S_IDLE;
			end
			default: begin
				state_n = ajb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ajb_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (exec_fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ajb_pkg::S_CMP)
		else $error("accepted item did not enter compare");
	a_cmp_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ajb_pkg::S_CMP |=> state_q == ajb_pkg::S_EXEC)
		else $error("compare not followed by update");
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid_q)
		else $error("update did not present a result");
	a_exec_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ajb_pkg::S_EXEC) && out_valid_q && !m_tready
		|=> state_q == ajb_pkg::S_EXEC)
		else $error("update left while result register busy");
`endif

endmodule

// ===== hdl/ajb_datapath.sv =====
// ajb_datapath: slot store, compare lanes, payload memory and result register
// of the audio jitter buffer; commanded by ajb_ctrl; uses ajb_pkg

module ajb_datapath #(
	parameter int SLOTS        = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ajb_pkg::cmd_t    cmd,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_wdata,
	input  logic [1:0]       opcode,
	input  logic [31:0]      session,
	input  logic [15:0]      sequence_req,
	input  logic [31:0]      payload,
	output ajb_pkg::status_t status,
	output logic [15:0]      out_sequence,
	output logic [31:0]      out_payload,
	output logic [3:0]       held_count
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam int MW = (CW > 4) ? CW : 4;

	// captured item
	logic [1:0]    op_q;
	logic [31:0]   sess_in_q;
	logic [15:0]   seq_in_q;
	logic [SW-1:0] pay_in_q;

	// store state
	logic [SLOTS-1:0] valid_q;
	logic [15:0]      slot_seq_q [SLOTS];
	logic [SW-1:0]    mem [SLOTS];
	logic [SW-1:0]    rdata_q;
	logic [CW-1:0]    count_q;
	logic [31:0]      session_q;
	logic [15:0]      expected_q;
	logic             known_q;
	logic             playing_q;
	logic [3:0]       prefill_q;

	// compare stage
	logic          match_s1;
	logic          later_s1;
	logic [IW-1:0] free_s1;
	logic [IW-1:0] hit_s1;

	// result register
	ajb_pkg::status_t status_q;
	logic [15:0]      oseq_q;
	logic [31:0]      opay_q;
	logic [3:0]       held_q;

	logic             new_sess;
	logic [15:0]      key;
	logic [SLOTS-1:0] eff_valid;
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] later;
	logic [IW-1:0]    match_idx;
	logic [IW-1:0]    free_idx;

	ajb_pkg::status_t st_n;
	logic             seq_early;
	logic             full;
	logic             push_wr;
	logic             pop_take;
	logic             skip;
	logic             lower;
	logic             start;
	logic             do_clear;
	logic [CW-1:0]    count_n;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			sess_in_q <= session;
			seq_in_q  <= sequence_req;
			pay_in_q  <= payload[SW-1:0];
		end
	end

	// slot compare lanes
	always_comb begin
		new_sess  = (op_q == ajb_pkg::OP_PUSH) && (!known_q || (sess_in_q != session_q));
		key       = (op_q == ajb_pkg::OP_PUSH) ? seq_in_q : expected_q;
		eff_valid = new_sess ? '0 : valid_q;
		match_idx = '0;
		free_idx  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = eff_valid[i] && (slot_seq_q[i] == key);
			later[i] = eff_valid[i] && ajb_pkg::seq_before(expected_q, slot_seq_q[i]);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) match_idx = IW'(i);
			if (!eff_valid[i]) free_idx = IW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			match_s1 <= |match;
			later_s1 <= |later;
			free_s1  <= free_idx;
			hit_s1   <= match_idx;
			rdata_q  <= mem[match_idx];
		end
	end

	// decision
	always_comb begin
		seq_early = ajb_pkg::seq_before(seq_in_q, expected_q);
		full      = (count_q >= CW'(SLOTS));
		st_n      = ajb_pkg::ST_WAIT;
		push_wr   = 1'b0;
		pop_take  = 1'b0;
		skip      = 1'b0;
		lower     = 1'b0;
		start     = 1'b0;
		do_clear  = 1'b0;
		case (op_q)
			ajb_pkg::OP_PUSH: begin
				if (match_s1) st_n = ajb_pkg::ST_DUPLICATE;
				else if (playing_q && seq_early) st_n = ajb_pkg::ST_TOO_OLD;
				else if (full) st_n = ajb_pkg::ST_FULL;
				else begin
					st_n    = ajb_pkg::ST_ACCEPTED;
					push_wr = 1'b1;
					lower   = !playing_q && seq_early;
				end
			end
			ajb_pkg::OP_POP: begin
				if (!known_q || (!playing_q && (MW'(count_q) < MW'(prefill_q)))) begin
					st_n = ajb_pkg::ST_WAIT;
				end else begin
					start = 1'b1;
					if (match_s1) begin
						st_n     = ajb_pkg::ST_FRAME;
						pop_take = 1'b1;
					end else if (later_s1) begin
						st_n = ajb_pkg::ST_MISSING;
						skip = 1'b1;
					end
				end
			end
			ajb_pkg::OP_CLEAR: begin
				st_n     = ajb_pkg::ST_CLEARED;
				do_clear = 1'b1;
			end
			default: begin
				st_n = ajb_pkg::ST_WAIT;
			end
		endcase
		if (do_clear) count_n = '0;
		else if (push_wr) count_n = count_q + CW'(1);
		else if (pop_take) count_n = count_q - CW'(1);
		else count_n = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			session_q  <= '0;
			expected_q <= '0;
			known_q    <= 1'b0;
			playing_q  <= 1'b0;
			prefill_q  <= 4'd2;
		end else begin
			if (cfg_we) prefill_q <= cfg_wdata;
			if (cmd.cmp && new_sess) begin
				valid_q    <= '0;
				count_q    <= '0;
				session_q  <= sess_in_q;
				expected_q <= seq_in_q;
				known_q    <= 1'b1;
				playing_q  <= 1'b0;
			end
			if (cmd.exec) begin
				count_q <= count_n;
				if (start) playing_q <= 1'b1;
				if (lower) expected_q <= seq_in_q;
				if (pop_take || skip) expected_q <= expected_q + 16'd1;
				if (push_wr) valid_q[free_s1] <= 1'b1;
				if (pop_take) valid_q[hit_s1] <= 1'b0;
				if (do_clear) begin
					valid_q    <= '0;
					session_q  <= '0;
					expected_q <= '0;
					known_q    <= 1'b0;
					playing_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push_wr) begin
			slot_seq_q[free_s1] <= seq_in_q;
			mem[free_s1]        <= pay_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= st_n;
			oseq_q   <= pop_take ? expected_q : 16'd0;
			opay_q   <= pop_take ? 32'(rdata_q) : 32'd0;
			held_q   <= 4'(count_n);
		end
	end

	assign status       = status_q;
	assign out_sequence = oseq_q;
	assign out_payload  = opay_q;
	assign held_count   = held_q;

endmodule

// ===== hdl/audio_jitter_buffer.sv =====
// audio_jitter_buffer: top level of the sequence-reordering jitter buffer
// instantiates ajb_ctrl and ajb_datapath; uses ajb_pkg
//
// Each transfer on the slave side is one command (push, pop or clear) and yields
// exactly one result transfer on the master side. An item goes through the
// accept, a compare of all slots in parallel with the payload memory read, then
// the update that loads the result register; a new item is accepted while the
// last result still waits, and the update stage stalls only when the result
// register is still full. Slot valid bits are flip-flops cleared by reset, so
// no clearing pass is needed. prefill_frames is written through cfg_we and
// cfg_wdata, only while the block is idle: a rule for the user, not enforced.

module audio_jitter_buffer #(
	parameter int SLOTS        = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,    // prefill_frames
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,      // session, sequence_req, payload
	input  logic [1:0]  s_tuser,      // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,      // out_sequence, out_payload, held_count, zero pad
	output logic [2:0]  m_tuser       // status
);

	ajb_pkg::cmd_t    cmd;
	ajb_pkg::status_t status;
	logic [15:0]      out_sequence;
	logic [31:0]      out_payload;
	logic [3:0]       held_count;

	ajb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ajb_datapath #(
		.SLOTS        (SLOTS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.opcode       (s_tuser),
		.session      (s_tdata[31:0]),
		.sequence_req (s_tdata[47:32]),
		.payload      (s_tdata[79:48]),
		.status       (status),
		.out_sequence (out_sequence),
		.out_payload  (out_payload),
		.held_count   (held_count)
	);

	assign m_tdata = {4'd0, held_count, out_payload, out_sequence};
	assign m_tuser = status;

endmodule
